### rtl/crt_mask_blur_bloom_filter_core_defines.svh
// ----------------------------------------------------------------------------
// crt mask blur bloom filter - assertion macros
// shared assertion forms for the filter core
// ----------------------------------------------------------------------------
`ifndef CRT_MASK_BLUR_BLOOM_FILTER_CORE_DEFINES_SVH
`define CRT_MASK_BLUR_BLOOM_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define CMBBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CMBBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cmbbf_pkg.sv
// ----------------------------------------------------------------------------
// cmbbf_pkg
// types and constants shared by the crt mask, blur and bloom filter
// ----------------------------------------------------------------------------
package cmbbf_pkg;

    localparam int QUEUE_DEPTH = 4;

    // bloom divide by 15300 through a reciprocal multiply and one correction
    localparam int BLOOM_DIV = 15300;
    localparam int PROD_W    = 22;
    localparam int RECIP_W   = 11;
    localparam int DIV_SHIFT = 24;
    localparam int DIV_RECIP = (1 << DIV_SHIFT) / BLOOM_DIV;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       row_end;
        logic       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       row_last;
    } t_pix_out;

    // one result to produce: bloom over a, c, e or plain pass of c
    typedef struct packed {
        logic bloom;
        logic last;
        t_rgb a;
        t_rgb c;
        t_rgb e;
    } t_op;

    typedef struct packed {
        logic [1:0]     cnt;
        t_op  [2:0]     slot;
    } t_job;

endpackage

### rtl/cmbbf_front.sv
// ----------------------------------------------------------------------------
// cmbbf_front
// accepts pixels, applies the phosphor mask and blur, and turns each pixel
// into a job of up to three results for the back end
// ----------------------------------------------------------------------------
module cmbbf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cmbbf_pkg::t_pix_in i_in_data,
    input  logic               i_q_full,
    output logic               o_q_push,
    output cmbbf_pkg::t_job    o_q_job
);

    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_ONE   = 2'd1;
    localparam logic [1:0] FILL_TWO   = 2'd2;
    localparam logic [1:0] FILL_FULL  = 2'd3;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    logic            r_enable, n_enable;
    logic [1:0]      r_phase, n_phase;
    logic [1:0]      r_fill, n_fill;
    cmbbf_pkg::t_rgb r_mw0, n_mw0, r_mw1, n_mw1;
    cmbbf_pkg::t_rgb r_bw0, n_bw0, r_bw1, n_bw1;

    logic            accept;
    logic [1:0]      phase_e, fill_e;
    cmbbf_pkg::t_rgb pix, m, nb;
    cmbbf_pkg::t_job job;

    function automatic cmbbf_pkg::t_rgb mask_px(cmbbf_pkg::t_rgb p, logic [1:0] ph);
        cmbbf_pkg::t_rgb q;
        q = p;
        unique case (ph)
            PHASE_0: begin
                q.g = p.g >> 1;
                q.b = p.b >> 1;
            end
            PHASE_1: begin
                q.r = p.r >> 1;
                q.b = p.b >> 1;
            end
            default: begin
                q.r = p.r >> 1;
                q.g = p.g >> 1;
            end
        endcase
        return q;
    endfunction

    function automatic logic [7:0] blur_ch(logic [7:0] a, logic [7:0] c, logic [7:0] e);
        logic [9:0] s;
        s = {2'b00, a} + {1'b0, c, 1'b0} + {2'b00, e};
        return s[9:2];
    endfunction

    function automatic cmbbf_pkg::t_rgb blur_px(cmbbf_pkg::t_rgb a, cmbbf_pkg::t_rgb c,
                                                cmbbf_pkg::t_rgb e);
        cmbbf_pkg::t_rgb q;
        q.r = blur_ch(a.r, c.r, e.r);
        q.g = blur_ch(a.g, c.g, e.g);
        q.b = blur_ch(a.b, c.b, e.b);
        return q;
    endfunction

    function automatic cmbbf_pkg::t_op op_pass(cmbbf_pkg::t_rgb p, logic last);
        cmbbf_pkg::t_op op;
        op       = '0;
        op.c     = p;
        op.last  = last;
        return op;
    endfunction

    function automatic cmbbf_pkg::t_op op_bloom(cmbbf_pkg::t_rgb a, cmbbf_pkg::t_rgb c,
                                                cmbbf_pkg::t_rgb e);
        cmbbf_pkg::t_op op;
        op       = '0;
        op.bloom = 1'b1;
        op.a     = a;
        op.c     = c;
        op.e     = e;
        return op;
    endfunction

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    always_comb begin
        pix     = '{r: i_in_data.red_in, g: i_in_data.green_in, b: i_in_data.blue_in};
        phase_e = i_in_data.frame_start ? PHASE_0 : r_phase;
        fill_e  = i_in_data.frame_start ? FILL_EMPTY : r_fill;
        m       = mask_px(pix, phase_e);
        nb      = blur_px(r_mw1, r_mw0, m);

        n_enable = i_cfg_we ? i_cfg_wdata : r_enable;
        n_phase  = r_phase;
        n_fill   = r_fill;
        n_mw0    = r_mw0;
        n_mw1    = r_mw1;
        n_bw0    = r_bw0;
        n_bw1    = r_bw1;
        job      = '0;

        if (accept) begin
            n_phase = phase_e;
            n_fill  = fill_e;
            if (!r_enable) begin
                job.cnt     = 2'd1;
                job.slot[0] = op_pass(pix, i_in_data.row_end);
                n_fill      = FILL_EMPTY;
            end else begin
                case (fill_e) inside
                    FILL_EMPTY: begin
                        n_mw0 = m;
                        if (i_in_data.row_end) begin
                            job.cnt     = 2'd1;
                            job.slot[0] = op_pass(m, 1'b1);
                        end else begin
                            n_fill = FILL_ONE;
                        end
                    end
                    FILL_ONE: begin
                        n_bw0 = r_mw0;
                        n_mw1 = r_mw0;
                        n_mw0 = m;
                        if (i_in_data.row_end) begin
                            job.cnt     = 2'd2;
                            job.slot[0] = op_pass(r_mw0, 1'b0);
                            job.slot[1] = op_pass(m, 1'b1);
                        end else begin
                            n_fill = FILL_TWO;
                        end
                    end
                    FILL_TWO, FILL_FULL: begin
                        job.cnt     = 2'd1;
                        job.slot[0] = (fill_e == FILL_TWO) ? op_pass(r_bw0, 1'b0)
                                                           : op_bloom(r_bw1, r_bw0, nb);
                        if (i_in_data.row_end) begin
                            job.cnt     = 2'd3;
                            job.slot[1] = op_bloom(r_bw0, nb, m);
                            job.slot[2] = op_pass(m, 1'b1);
                        end else begin
                            n_fill = FILL_FULL;
                        end
                        n_bw1 = r_bw0;
                        n_bw0 = nb;
                        n_mw1 = r_mw0;
                        n_mw0 = m;
                    end
                    default: begin
                        n_fill = FILL_EMPTY;
                    end
                endcase
            end
            if (i_in_data.row_end) begin
                n_fill  = FILL_EMPTY;
                n_phase = (phase_e == PHASE_2) ? PHASE_0 : phase_e + 2'd1;
            end
        end
    end

    assign o_q_push = accept && (job.cnt != 2'd0);
    assign o_q_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_phase  <= PHASE_0;
            r_fill   <= FILL_EMPTY;
        end else begin
            r_enable <= n_enable;
            r_phase  <= n_phase;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mw0 <= n_mw0;
        r_mw1 <= n_mw1;
        r_bw0 <= n_bw0;
        r_bw1 <= n_bw1;
    end

endmodule

### rtl/cmbbf_queue.sv
// ----------------------------------------------------------------------------
// cmbbf_queue
// short job queue between the front end and the bloom back end
// ----------------------------------------------------------------------------
module cmbbf_queue #(
    parameter int DEPTH = cmbbf_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmbbf_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output cmbbf_pkg::t_job o_job,
    output logic            o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmbbf_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### rtl/cmbbf_back.sv
// ----------------------------------------------------------------------------
// cmbbf_back
// walks the slots of each job and runs them through the bloom pipeline:
// differences and sum, product, reciprocal multiply, correction and clamp
// ----------------------------------------------------------------------------
module cmbbf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cmbbf_pkg::t_job     i_job,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cmbbf_pkg::t_pix_out o_out_data
);

    localparam int PW = cmbbf_pkg::PROD_W;
    localparam int RW = cmbbf_pkg::RECIP_W;
    localparam int SH = cmbbf_pkg::DIV_SHIFT;

    logic                advance, issue;
    logic [1:0]          r_slot;
    cmbbf_pkg::t_op      op;

    // stage a: centre, channel sum, signed neighbour difference
    logic                r_a_v, r_a_bloom, r_a_last;
    logic [2:0][7:0]     r_a_mid;
    logic [9:0]          r_a_sum;
    logic signed [10:0]  r_a_d [3];
    // stage b: magnitude of d * sum * 7
    logic                r_b_v, r_b_bloom, r_b_last;
    logic [2:0][7:0]     r_b_mid;
    logic [2:0]          r_b_neg;
    logic [PW-1:0]       r_b_p [3];
    // stage c: quotient estimate
    logic                r_c_v, r_c_bloom, r_c_last;
    logic [2:0][7:0]     r_c_mid;
    logic [2:0]          r_c_neg;
    logic [PW-1:0]       r_c_p [3];
    logic [7:0]          r_c_q0 [3];
    // output register
    logic                r_out_v;
    cmbbf_pkg::t_pix_out r_out_data;

    logic [2:0][7:0]     av, cv, ev;
    logic [8:0]          mag [3];
    logic [18:0]         prod [3];
    logic [PW+RW-1:0]    rprod [3];
    logic [PW-1:0]       qd [3], rem [3];
    logic [8:0]          q [3];
    logic signed [10:0]  v [3];
    logic [2:0][7:0]     res;

    assign advance = !r_out_v || !i_out_stall;
    assign issue   = advance && !i_q_empty;
    assign op      = i_job.slot[r_slot];
    assign o_q_pop = issue && (r_slot == i_job.cnt - 2'd1);

    always_comb begin
        av = op.a;
        cv = op.c;
        ev = op.e;
        for (int k = 0; k < 3; k++) begin
            mag[k]   = r_a_d[k][10] ? 9'(-r_a_d[k]) : r_a_d[k][8:0];
            prod[k]  = 19'(mag[k] * r_a_sum);
            rprod[k] = (PW+RW)'(r_b_p[k]) * (PW+RW)'(cmbbf_pkg::DIV_RECIP);
            qd[k]    = PW'(r_c_q0[k]) * PW'(cmbbf_pkg::BLOOM_DIV);
            rem[k]   = r_c_p[k] - qd[k];
            q[k]     = {1'b0, r_c_q0[k]} + 9'(rem[k] >= PW'(cmbbf_pkg::BLOOM_DIV));
            v[k]     = r_c_neg[k] ? $signed({3'b000, r_c_mid[k]}) - $signed({2'b00, q[k]})
                                  : $signed({3'b000, r_c_mid[k]}) + $signed({2'b00, q[k]});
            if (!r_c_bloom) begin
                res[k] = r_c_mid[k];
            end else if (v[k][10]) begin
                res[k] = 8'd0;
            end else if (v[k][9:8] != 2'b00) begin
                res[k] = 8'hFF;
            end else begin
                res[k] = v[k][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (advance) begin
            if (issue) begin
                r_slot <= o_q_pop ? 2'd0 : r_slot + 2'd1;
            end
            r_a_v   <= issue;
            r_b_v   <= r_a_v;
            r_c_v   <= r_b_v;
            r_out_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_bloom <= op.bloom;
            r_a_last  <= op.last;
            r_a_mid   <= cv;
            r_a_sum   <= {2'b00, cv[0]} + {2'b00, cv[1]} + {2'b00, cv[2]};
            for (int k = 0; k < 3; k++) begin
                r_a_d[k] <= $signed({3'b000, av[k]}) + $signed({3'b000, ev[k]})
                          - $signed({2'b00, cv[k], 1'b0});
            end

            r_b_bloom <= r_a_bloom;
            r_b_last  <= r_a_last;
            r_b_mid   <= r_a_mid;
            for (int k = 0; k < 3; k++) begin
                r_b_neg[k] <= r_a_d[k][10];
                // times seven as eight minus one
                r_b_p[k]   <= PW'({prod[k], 3'b000}) - PW'(prod[k]);
            end

            r_c_bloom <= r_b_bloom;
            r_c_last  <= r_b_last;
            r_c_mid   <= r_b_mid;
            r_c_neg   <= r_b_neg;
            for (int k = 0; k < 3; k++) begin
                r_c_p[k]  <= r_b_p[k];
                r_c_q0[k] <= rprod[k][SH +: 8];
            end

            r_out_data.red_out   <= res[2];
            r_out_data.green_out <= res[1];
            r_out_data.blue_out  <= res[0];
            r_out_data.row_last  <= r_c_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_data;

endmodule

### rtl/crt_mask_blur_bloom_filter_core.sv
// ----------------------------------------------------------------------------
// crt_mask_blur_bloom_filter_core
// CRT look filter for a raster RGB stream. The front end takes one pixel per
// cycle unless stalled, applies the row-phase phosphor mask and the 1-2-1 blur,
// and queues a job of up to three results; a pixel that ends a row flushes the
// row and yields up to three results; the back end delivers one result per
// cycle unless the output stalls. The job queue (QUEUE_DEPTH entries, default
// four) absorbs these bursts; the input stalls only when it is full. After its
// job reaches the head of the queue, a result passes registered stages for
// difference and sum, product, reciprocal multiply, and correction and clamp.
// With the effect off each pixel gives one result. effect_enable resets to 1
// and is written through i_cfg_we / i_cfg_wdata.
// ----------------------------------------------------------------------------
`include "crt_mask_blur_bloom_filter_core_defines.svh"

module crt_mask_blur_bloom_filter_core #(
    parameter int QUEUE_DEPTH = cmbbf_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cmbbf_pkg::t_pix_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cmbbf_pkg::t_pix_out o_out_data
);

    logic            q_push, q_pop, q_full, q_empty;
    cmbbf_pkg::t_job q_wjob, q_rjob;

    cmbbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (q_wjob)
    );

    cmbbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_wjob),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_rjob),
        .o_empty (q_empty)
    );

    cmbbf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_rjob),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `CMBBF_ASSERT_NOW(a_push_not_full, i_clk, i_rst_n, q_push, !q_full, "job pushed into full queue")
    `CMBBF_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, q_pop, !q_empty, "job popped from empty queue")
    `CMBBF_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, q_full && !q_pop, q_full, "queue lost a job")

endmodule
